FILE: src/fgn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_pkg: shared definitions for the fractal gradient noise unit
// Fixed-point formats, field widths, register indexes, sequencer schedule
// limits and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fgn_pkg;

   // fixed-point format and lattice
   localparam int FRAC_BITS       = 16;
   localparam int FX_ONE          = 1 << FRAC_BITS;
   localparam int TABLE_BITS      = 8;
   localparam int TABLE_SIZE      = 1 << TABLE_BITS;
   localparam int MAX_OCTAVES_DEF = 8;

   // stream payload widths
   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_OCTAVE_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERSISTENCE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_SCALE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_LOW      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_HIGH     = 3'd4;

   // request kinds carried in tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // sequencer schedule
   localparam int STEP_W = 5;
   localparam int DIV_QBITS = 24;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd3;
   localparam logic [STEP_W-1:0] OCT_LAST_STEP  = 5'd24;
   localparam logic [STEP_W-1:0] DIV_LAST_STEP  = 5'(DIV_QBITS);
   localparam logic [STEP_W-1:0] MAP_LAST_STEP  = 5'd1;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_INIT   = 3'd1,
      MODE_OCTAVE = 3'd2,
      MODE_DIVIDE = 3'd3,
      MODE_MAP    = 3'd4
   } fgn_mode_type;

   typedef struct packed {
      fgn_mode_type      mode;
      logic [STEP_W-1:0] step;
      logic              load_we;
      logic              eval_start;
      logic              rsp_load;
   } fgn_cmd_type;

   typedef struct packed {
      logic last_octave;
   } fgn_status_type;

endpackage
`default_nettype wire

FILE: src/fgn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_ctrl: sequencer for the fractal gradient noise unit
// Walks init, per-octave, divide and output-mapping schedules, and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
module fgn_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [fgn_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output fgn_pkg::fgn_cmd_type                cmd,
   input  fgn_pkg::fgn_status_type             status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INIT = 5'b00010,
      ST_OCT  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_MAP  = 5'b10000
   } fgn_state_type;

   fgn_state_type                  state_ff, state_in;
   logic [fgn_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and command
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      cmd.mode       = fgn_pkg::MODE_IDLE;
      cmd.step       = step_ff;
      cmd.load_we    = 1'b0;
      cmd.eval_start = 1'b0;
      cmd.rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0] == fgn_pkg::CMD_EVAL) begin
                  cmd.eval_start = 1'b1;
                  state_in       = ST_INIT;
                  step_in        = '0;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_INIT: begin
            cmd.mode = fgn_pkg::MODE_INIT;
            if (step_ff == fgn_pkg::INIT_LAST_STEP) begin
               state_in = ST_OCT;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OCT: begin
            cmd.mode = fgn_pkg::MODE_OCTAVE;
            if (step_ff == fgn_pkg::OCT_LAST_STEP) begin
               step_in = '0;
               if (status.last_octave) begin
                  state_in = ST_DIV;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.mode = fgn_pkg::MODE_DIVIDE;
            if (step_ff == fgn_pkg::DIV_LAST_STEP) begin
               state_in = ST_MAP;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MAP: begin
            cmd.mode = fgn_pkg::MODE_MAP;
            if (step_ff != fgn_pkg::MAP_LAST_STEP) begin
               step_in = step_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
               step_in      = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // output valid: set on load of a new result, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // schedule stays within its octave window
   a_oct_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OCT) |-> (step_ff <= fgn_pkg::OCT_LAST_STEP))
      else $error("octave step beyond schedule");

   // a result only appears out of the mapping stage
   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_MAP))
      else $error("response raised outside mapping stage");

   // an evaluate request starts the init schedule
   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser[0] == fgn_pkg::CMD_EVAL)) |=>
         (state_ff == ST_INIT && step_ff == '0))
      else $error("evaluate request did not start init");

endmodule
`default_nettype wire

FILE: src/fgn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_datapath: arithmetic and storage for the fractal gradient noise unit
// Permutation memory, one shared registered multiplier, gradient and blend
// registers, octave accumulators, a radix-2 divider and the output register.
// ----------------------------------------------------------------------------
module fgn_datapath #(
   parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [fgn_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic [fgn_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire                                 csr_we,
   input  wire  [fgn_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [fgn_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  fgn_pkg::fgn_cmd_type                cmd,
   output fgn_pkg::fgn_status_type             status
);

   localparam int F      = fgn_pkg::FRAC_BITS;
   localparam int TB     = fgn_pkg::TABLE_BITS;
   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int P0_W   = 56;
   localparam int QB     = fgn_pkg::DIV_QBITS;
   localparam int TOT_W  = 44;
   localparam int AS_W   = 22;
   localparam logic signed [59:0] SAT_MAX = 60'sd2147483647;
   localparam logic signed [59:0] SAT_MIN = -60'sd2147483648;

   // gradient for the low four hash bits
   function automatic logic signed [18:0] grad(input logic [3:0] h,
                                               input logic signed [17:0] x,
                                               input logic signed [17:0] y,
                                               input logic signed [17:0] z);
      logic signed [18:0] u;
      logic signed [18:0] v;
      u = (h < 4'd8) ? 19'(x) : 19'(y);
      if (h < 4'd4) begin
         v = 19'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = 19'(x);
      end else begin
         v = 19'(z);
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   // request fields
   logic [TB-1:0]      tbl_index;
   logic [7:0]         tbl_value;
   assign tbl_index = req_tdata[7:0];
   assign tbl_value = req_tdata[15:8];

   // configuration registers
   logic [3:0]          oct_cfg_ff;
   logic [16:0]         pers_ff;
   logic [23:0]         base_ff;
   logic signed [31:0]  lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cfg_ff <= 4'd4;
         pers_ff    <= 17'd32768;
         base_ff    <= 24'd65536;
         lo_ff      <= -32'sd65536;
         hi_ff      <= 32'sd65536;
      end else if (csr_we) begin
         unique case (csr_addr)
            fgn_pkg::CSR_OCTAVE_COUNT: oct_cfg_ff <= csr_wdata[3:0];
            fgn_pkg::CSR_PERSISTENCE:  pers_ff    <= csr_wdata[16:0];
            fgn_pkg::CSR_BASE_SCALE:   base_ff    <= csr_wdata[23:0];
            fgn_pkg::CSR_OUT_LOW:      lo_ff      <= csr_wdata;
            fgn_pkg::CSR_OUT_HIGH:     hi_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped octave count and persistence
   logic [OCT_W-1:0] oct_num;
   logic [16:0]      pers_c;
   always_comb begin
      if (oct_cfg_ff == 4'd0) begin
         oct_num = OCT_W'(1);
      end else if (int'(oct_cfg_ff) > MAX_OCTAVES) begin
         oct_num = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_num = OCT_W'(oct_cfg_ff);
      end
      pers_c = (pers_ff > 17'(fgn_pkg::FX_ONE)) ? 17'(fgn_pkg::FX_ONE) : pers_ff;
   end

   // state registers
   logic signed [31:0]      coord_x_ff, coord_y_ff, coord_z_ff;
   logic [P0_W-1:0]         p0x_ff, p0y_ff, p0z_ff;
   logic [OCT_W-1:0]        oct_ff;
   logic [TB-1:0]           cell_x_ff, cell_y_ff, cell_z_ff;
   logic [F-1:0]            frac_x_ff, frac_y_ff, frac_z_ff;
   logic signed [17:0]      fade_u_ff, fade_v_ff, fade_w_ff;
   logic signed [21:0]      fb_ff;
   logic [TB-1:0]           ha_ff, hb_ff, haa_ff, hab_ff, hba_ff, hbb_ff;
   logic signed [18:0]      g_ff [8];
   logic signed [19:0]      n00_ff, n01_ff, n10_ff, n11_ff, n0_ff, n1_ff, n_ff;
   logic [16:0]             amp_ff;
   logic [AS_W-1:0]         amp_sum_ff;
   logic signed [TOT_W-1:0] total_ff;
   logic [AS_W-1:0]         rem_ff;
   logic [QB-1:0]           quo_ff;
   logic                    neg_ff;
   logic signed [58:0]      prod_ff;
   logic [TB-1:0]           rd_addr;
   logic [7:0]              rd_data_ff;
   logic [31:0]             rsp_data_ff;
   logic [7:0]              perm_mem [fgn_pkg::TABLE_SIZE];

   assign status.last_octave = (oct_ff == OCT_W'(oct_num - 1'b1));
   assign rsp_tdata = rsp_data_ff;

   // octave-scaled positions
   logic [P0_W-1:0] shx, shy, shz;
   assign shx = p0x_ff << oct_ff;
   assign shy = p0y_ff << oct_ff;
   assign shz = p0z_ff << oct_ff;

   // lattice offsets as signed values
   logic signed [17:0] x0, y0, z0, x1, y1, z1;
   assign x0 = $signed({2'b00, frac_x_ff});
   assign y0 = $signed({2'b00, frac_y_ff});
   assign z0 = $signed({2'b00, frac_z_ff});
   assign x1 = x0 - 18'sd65536;
   assign y1 = y0 - 18'sd65536;
   assign z1 = z0 - 18'sd65536;

   // product scaled back by one fraction width
   logic signed [58:0] pfl;
   assign pfl = prod_ff >>> F;

   // fade input for the axis in work
   logic [F-1:0]       axis_t;
   logic signed [21:0] fade_a;
   always_comb begin
      case (cmd.step) inside
         [5'd1:5'd4]: axis_t = frac_x_ff;
         [5'd5:5'd8]: axis_t = frac_y_ff;
         default:     axis_t = frac_z_ff;
      endcase
      fade_a = 22'(6 * $signed({6'd0, axis_t}) - 15 * fgn_pkg::FX_ONE);
   end

   // quotient as a signed value
   logic signed [24:0] r_val;
   assign r_val = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   // shared multiplier operand select
   logic signed [33:0] mul_a;
   logic signed [24:0] mul_b;
   logic               mul_en;
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      unique case (cmd.mode)
         fgn_pkg::MODE_INIT: begin
            mul_b = $signed({1'b0, base_ff});
            case (cmd.step)
               5'd0: begin mul_a = 34'(coord_x_ff); mul_en = 1'b1; end
               5'd1: begin mul_a = 34'(coord_y_ff); mul_en = 1'b1; end
               5'd2: begin mul_a = 34'(coord_z_ff); mul_en = 1'b1; end
               default: ;
            endcase
         end
         fgn_pkg::MODE_OCTAVE: begin
            mul_en = 1'b1;
            case (cmd.step) inside
               5'd1, 5'd5, 5'd9: begin
                  mul_a = $signed({18'd0, axis_t});
                  mul_b = 25'(fade_a);
               end
               5'd2, 5'd6, 5'd10: begin
                  mul_a = $signed({18'd0, axis_t});
                  mul_b = $signed({9'd0, axis_t});
               end
               5'd3, 5'd7, 5'd11: begin
                  mul_a = $signed({18'd0, axis_t});
                  mul_b = $signed(pfl[24:0]);
               end
               5'd4, 5'd8, 5'd12: begin
                  mul_a = 34'(fb_ff);
                  mul_b = $signed(pfl[24:0]);
               end
               5'd13: begin
                  mul_a = 34'(g_ff[1]) - 34'(g_ff[0]);
                  mul_b = 25'(fade_u_ff);
               end
               5'd14: begin
                  mul_a = 34'(g_ff[3]) - 34'(g_ff[2]);
                  mul_b = 25'(fade_u_ff);
               end
               5'd15: begin
                  mul_a = 34'(g_ff[5]) - 34'(g_ff[4]);
                  mul_b = 25'(fade_u_ff);
               end
               5'd16: begin
                  mul_a = 34'(g_ff[7]) - 34'(g_ff[6]);
                  mul_b = 25'(fade_u_ff);
               end
               5'd17: begin
                  mul_a = 34'(n01_ff) - 34'(n00_ff);
                  mul_b = 25'(fade_v_ff);
               end
               5'd18: begin
                  mul_a = 34'(n11_ff) - 34'(n10_ff);
                  mul_b = 25'(fade_v_ff);
               end
               5'd20: begin
                  mul_a = 34'(n1_ff) - 34'(n0_ff);
                  mul_b = 25'(fade_w_ff);
               end
               5'd22: begin
                  mul_a = 34'(n_ff);
                  mul_b = $signed({8'd0, amp_ff});
               end
               5'd23: begin
                  mul_a = $signed({17'd0, amp_ff});
                  mul_b = $signed({8'd0, pers_c});
               end
               default: mul_en = 1'b0;
            endcase
         end
         fgn_pkg::MODE_MAP: begin
            if (cmd.step == 5'd0) begin
               mul_a  = 34'(hi_ff) - 34'(lo_ff);
               mul_b  = r_val;
               mul_en = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 59'(mul_a * mul_b);
      end
   end

   // permutation memory read address
   always_comb begin
      case (cmd.step)
         5'd1:    rd_addr = cell_x_ff;
         5'd2:    rd_addr = cell_x_ff + 1'b1;
         5'd3:    rd_addr = ha_ff;
         5'd4:    rd_addr = ha_ff + 1'b1;
         5'd5:    rd_addr = hb_ff;
         5'd6:    rd_addr = hb_ff + 1'b1;
         5'd7:    rd_addr = haa_ff;
         5'd8:    rd_addr = hba_ff;
         5'd9:    rd_addr = hab_ff;
         5'd10:   rd_addr = hbb_ff;
         5'd11:   rd_addr = haa_ff + 1'b1;
         5'd12:   rd_addr = hba_ff + 1'b1;
         5'd13:   rd_addr = hab_ff + 1'b1;
         5'd14:   rd_addr = hbb_ff + 1'b1;
         default: rd_addr = cell_x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         perm_mem[tbl_index] <= tbl_value;
      end
      rd_data_ff <= perm_mem[rd_addr];
   end

   // divider restore step
   logic [AS_W:0] rem2;
   logic          qbit;
   logic [TOT_W-1:0] mag;
   always_comb begin
      rem2 = {rem_ff, quo_ff[QB-1]};
      qbit = (rem2 >= {1'b0, amp_sum_ff});
      mag  = total_ff[TOT_W-1] ? TOT_W'(-total_ff) : TOT_W'(total_ff);
   end

   // output mapping and saturation
   logic signed [32:0] hsum;
   logic signed [59:0] map_sum;
   logic [31:0]        map_sat;
   always_comb begin
      hsum    = (33'(hi_ff) + 33'(lo_ff)) >>> 1;
      map_sum = 60'(prod_ff >>> (F + 1)) + 60'(hsum);
      if (map_sum > SAT_MAX) begin
         map_sat = 32'(SAT_MAX);
      end else if (map_sum < SAT_MIN) begin
         map_sat = 32'(SAT_MIN);
      end else begin
         map_sat = 32'(map_sum);
      end
   end

   // octave counter
   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff <= '0;
      end else if (cmd.eval_start) begin
         oct_ff <= '0;
      end else if (cmd.mode == fgn_pkg::MODE_OCTAVE &&
                   cmd.step == fgn_pkg::OCT_LAST_STEP) begin
         oct_ff <= oct_ff + 1'b1;
      end
   end

   // datapath write-back
   always_ff @(posedge clock) begin
      if (cmd.eval_start) begin
         coord_x_ff <= $signed(req_tdata[47:16]);
         coord_y_ff <= $signed(req_tdata[79:48]);
         coord_z_ff <= $signed(req_tdata[111:80]);
         total_ff   <= '0;
         amp_sum_ff <= '0;
         amp_ff     <= 17'(fgn_pkg::FX_ONE);
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= map_sat;
      end
      unique case (cmd.mode)
         fgn_pkg::MODE_INIT: begin
            case (cmd.step)
               5'd1: p0x_ff <= prod_ff[P0_W-1:0];
               5'd2: p0y_ff <= prod_ff[P0_W-1:0];
               5'd3: p0z_ff <= prod_ff[P0_W-1:0];
               default: ;
            endcase
         end
         fgn_pkg::MODE_OCTAVE: begin
            case (cmd.step)
               5'd0: begin
                  cell_x_ff <= shx[2*F +: TB];
                  cell_y_ff <= shy[2*F +: TB];
                  cell_z_ff <= shz[2*F +: TB];
                  frac_x_ff <= shx[F +: F];
                  frac_y_ff <= shy[F +: F];
                  frac_z_ff <= shz[F +: F];
               end
               5'd2: begin
                  fb_ff <= 22'(pfl + 10 * fgn_pkg::FX_ONE);
                  ha_ff <= rd_data_ff + cell_y_ff;
               end
               5'd3: hb_ff  <= rd_data_ff + cell_y_ff;
               5'd4: haa_ff <= rd_data_ff + cell_z_ff;
               5'd5: begin
                  hab_ff    <= rd_data_ff + cell_z_ff;
                  fade_u_ff <= 18'(pfl);
               end
               5'd6: begin
                  hba_ff <= rd_data_ff + cell_z_ff;
                  fb_ff  <= 22'(pfl + 10 * fgn_pkg::FX_ONE);
               end
               5'd7:  hbb_ff <= rd_data_ff + cell_z_ff;
               5'd8:  g_ff[0] <= grad(rd_data_ff[3:0], x0, y0, z0);
               5'd9: begin
                  g_ff[1]   <= grad(rd_data_ff[3:0], x1, y0, z0);
                  fade_v_ff <= 18'(pfl);
               end
               5'd10: begin
                  g_ff[2] <= grad(rd_data_ff[3:0], x0, y1, z0);
                  fb_ff   <= 22'(pfl + 10 * fgn_pkg::FX_ONE);
               end
               5'd11: g_ff[3] <= grad(rd_data_ff[3:0], x1, y1, z0);
               5'd12: g_ff[4] <= grad(rd_data_ff[3:0], x0, y0, z1);
               5'd13: begin
                  g_ff[5]   <= grad(rd_data_ff[3:0], x1, y0, z1);
                  fade_w_ff <= 18'(pfl);
               end
               5'd14: begin
                  g_ff[6] <= grad(rd_data_ff[3:0], x0, y1, z1);
                  n00_ff  <= 20'(g_ff[0]) + 20'(pfl);
               end
               5'd15: begin
                  g_ff[7] <= grad(rd_data_ff[3:0], x1, y1, z1);
                  n01_ff  <= 20'(g_ff[2]) + 20'(pfl);
               end
               5'd16: n10_ff <= 20'(g_ff[4]) + 20'(pfl);
               5'd17: n11_ff <= 20'(g_ff[6]) + 20'(pfl);
               5'd18: n0_ff  <= n00_ff + 20'(pfl);
               5'd19: n1_ff  <= n10_ff + 20'(pfl);
               5'd21: n_ff   <= n0_ff + 20'(pfl);
               5'd22: amp_sum_ff <= amp_sum_ff + AS_W'(amp_ff);
               5'd23: total_ff   <= total_ff + TOT_W'(prod_ff);
               5'd24: amp_ff     <= 17'(pfl);
               default: ;
            endcase
         end
         fgn_pkg::MODE_DIVIDE: begin
            if (cmd.step == 5'd0) begin
               rem_ff <= AS_W'(mag >> QB);
               quo_ff <= mag[QB-1:0];
               neg_ff <= total_ff[TOT_W-1];
            end else begin
               rem_ff <= qbit ? AS_W'(rem2 - {1'b0, amp_sum_ff}) : AS_W'(rem2);
               quo_ff <= {quo_ff[QB-2:0], qbit};
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/fractal_gradient_noise_3d_unit.sv
`default_nettype none
// Load request: writes one permutation entry, no response.
// Evaluate request: response valid after init, N octaves (N = clamped octave
// count), divide and mapping; each octave runs 25 steps on one shared multiplier and one
// memory read port, the divider adds 25 steps, init 4 and mapping 2. One request
// is worked at a time: the next is taken after the result is loaded. Reset is
// synchronous: control, configuration and octave counter return to defaults.
// ----------------------------------------------------------------------------
// fractal_gradient_noise_3d_unit: fractal 3D gradient noise engine
// Octave-summed improved gradient noise in Q16.16, normalized and mapped to a
// programmable output range. The permutation memory keeps its contents across
// reset and must be loaded before evaluation.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_3d_unit #(
   parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // tdata: table_index[7:0], table_value[15:8], coord_x[47:16],
   //        coord_y[79:48], coord_z[111:80]
   input  wire  [fgn_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: command[0]
   input  wire  [fgn_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // tdata: noise_value[31:0]
   output logic [fgn_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire                               csr_we,
   input  wire  [fgn_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire  [fgn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fgn_pkg::fgn_cmd_type    cmd;
   fgn_pkg::fgn_status_type status;

   fgn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   fgn_datapath #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire
